FILE: rtl/siam_pkg.sv
`default_nettype none

package siam_pkg;

   // Operation codes carried on req_mode
   localparam logic [2:0] MODE_PUSH_LEFT  = 3'd0;
   localparam logic [2:0] MODE_PUSH_RIGHT = 3'd1;
   localparam logic [2:0] MODE_REG_WRITE  = 3'd2;
   localparam logic [2:0] MODE_REG_READ   = 3'd3;
   localparam logic [2:0] MODE_RUN        = 3'd4;
   localparam logic [2:0] MODE_FLUSH      = 3'd5;

   // Configuration register indexes
   localparam logic CSR_FLUSH_SIDE  = 1'b0;
   localparam logic CSR_FLUSH_LIMIT = 1'b1;

   // flush_side codes
   localparam logic SIDE_RIGHT = 1'b0;
   localparam logic SIDE_LEFT  = 1'b1;

   localparam logic [2:0] COLUMN_WRAP   = 3'd7;
   localparam logic [4:0] FIELD5_MAX    = 5'd31;
   localparam logic [4:0] LIMIT_RESET   = 5'd8;

   // Queue control from the sequencer
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } q_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/siam_queue.sv
`default_nettype none

module siam_queue
   import siam_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int SLOT_W = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire q_ctl_type                    ctl,
   input  wire logic [SLOT_W-1:0]            wr_slot,
   input  wire logic [31:0]                  wr_index,
   output logic      [SLOT_W-1:0]            front_slot,
   output logic      [31:0]                  front_index,
   output logic      [$clog2(DEPTH+1)-1:0]   level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [SLOT_W-1:0] slot_mem  [DEPTH];
   logic [31:0]       index_mem [DEPTH];

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] front_slot_ff;
   logic [31:0]       front_index_ff;

   // pointer and occupancy update; clear wins
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (ctl.push) begin
            tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
         end
         if (ctl.pop) begin
            head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
         end
         if (ctl.push && !ctl.pop) begin
            count_in = count_ff + 1'b1;
         end else if (ctl.pop && !ctl.push) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage, front word read registered from the head
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         slot_mem[tail_ff]  <= wr_slot;
         index_mem[tail_ff] <= wr_index;
      end
      front_slot_ff  <= slot_mem[head_ff];
      front_index_ff <= index_mem[head_ff];
   end

   assign front_slot  = front_slot_ff;
   assign front_index = front_index_ff;
   assign level       = count_ff;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue level beyond depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> count_ff == '0 && head_ff == tail_ff)
      else $error("queue not empty after clear");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && !ctl.pop && !ctl.clear) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the queue");

endmodule

`default_nettype wire

FILE: rtl/sparse_index_match_accumulator_core.sv
`default_nettype none

// Sorted index intersection with register accumulation. Every accepted word
// (start high while busy is low) gives exactly one result word, strobed on
// rsp_valid for a single cycle; the receiver cannot stall, so the result must
// be captured when it appears. Pushes, register writes, flushes and unused
// modes pass through EXEC and RESP before the strobe, a register read also
// through REG_RD. A run passes EXEC, a merge loop of MRG_RD and MRG_CMP, then
// LIMIT and RESP: one shared 32-bit comparator looks at the two queue fronts,
// each front is re-read from queue memory after every pop, and a match spends
// one more state, MAT_WR, on the register file read-add-write. Full queues
// give at most about 2*QUEUE_DEPTH comparisons. No clearing pass is needed
// after reset: the register files carry valid bits and read as zero until
// written. Configuration writes are always taken.
module sparse_index_match_accumulator_core
   import siam_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int REG_SLOTS   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_mode,
   input  wire logic        req_side,
   input  wire logic [3:0]  req_slot,
   input  wire logic [31:0] req_index_value,
   input  wire logic [15:0] req_reg_data,
   input  wire logic [31:0] req_column_tag,
   // result channel
   output logic             rsp_valid,
   output logic [15:0]      rsp_read_data,
   output logic [4:0]       rsp_match_count,
   output logic [4:0]       rsp_left_level,
   output logic [4:0]       rsp_right_level,
   output logic             rsp_flushed,
   output logic             rsp_overflow,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_data
);

   localparam int SLOT_W = $clog2(REG_SLOTS);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W  = CNT_W + 5;
   localparam logic [6:0] SLOTS7 = 7'(REG_SLOTS);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_REG_RD  = 3'd2;
   localparam logic [2:0] S_MRG_RD  = 3'd3;
   localparam logic [2:0] S_MRG_CMP = 3'd4;
   localparam logic [2:0] S_MAT_WR  = 3'd5;
   localparam logic [2:0] S_LIMIT   = 3'd6;
   localparam logic [2:0] S_RESP    = 3'd7;

   function automatic logic [4:0] sat5(input logic [CNT_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      if (w > CMP_W'(FIELD5_MAX)) begin
         return FIELD5_MAX;
      end
      return w[4:0];
   endfunction

   logic [2:0]        state_ff, state_in;

   // captured command word
   logic [2:0]        mode_ff;
   logic              side_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [31:0]       index_ff;
   logic [15:0]       data_ff;
   logic [31:0]       tag_ff;

   // per-item status
   logic [15:0]       read_ff, read_in;
   logic [4:0]        match_ff, match_in;
   logic              flushed_ff, flushed_in;
   logic              overflow_ff, overflow_in;

   // column tracking and configuration
   logic [31:0]       prev_tag_ff, prev_tag_in;
   logic [2:0]        col_pos_ff, col_pos_in;
   logic              flush_side_ff;
   logic [4:0]        flush_limit_ff;

   // slots of the matched fronts
   logic [SLOT_W-1:0] mls_ff, mls_in;
   logic [SLOT_W-1:0] mrs_ff, mrs_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_read_ff;
   logic [4:0]        rsp_match_ff;
   logic [4:0]        rsp_left_ff;
   logic [4:0]        rsp_right_ff;
   logic              rsp_flushed_ff;
   logic              rsp_overflow_ff;

   // queues
   q_ctl_type         lq_ctl, rq_ctl;
   logic [SLOT_W-1:0] lq_slot, rq_slot;
   logic [31:0]       lq_index, rq_index;
   logic [CNT_W-1:0]  lq_level, rq_level;

   // register files
   logic [15:0]       left_rf_mem  [REG_SLOTS];
   logic [15:0]       right_rf_mem [REG_SLOTS];
   logic [REG_SLOTS-1:0] lvalid_ff, rvalid_ff;
   logic [15:0]       lrd_ff, rrd_ff;
   logic              lrd_valid_ff, rrd_valid_ff;
   logic [SLOT_W-1:0] l_raddr, r_raddr;
   logic              l_we, r_we;
   logic [SLOT_W-1:0] l_waddr, r_waddr;
   logic [15:0]       l_wdata, r_wdata;
   logic [15:0]       lval, rval;

   logic              accept;
   logic [6:0]        slot7;
   logic [SLOT_W-1:0] slot_red;
   logic              lq_full, rq_full;
   logic              fronts_equal, left_greater;
   logic              over_limit;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // slot reduced modulo the register file size (slot < 2 * REG_SLOTS)
   assign slot7    = 7'(req_slot);
   assign slot_red = (slot7 >= SLOTS7) ? SLOT_W'(slot7 - SLOTS7) : SLOT_W'(slot7);

   assign lq_full = (lq_level == CNT_W'(QUEUE_DEPTH));
   assign rq_full = (rq_level == CNT_W'(QUEUE_DEPTH));

   // the shared front comparator
   assign fronts_equal = (lq_index == rq_index);
   assign left_greater = (lq_index > rq_index);

   assign over_limit = (CMP_W'(lq_level) > CMP_W'(flush_limit_ff)) ||
                       (CMP_W'(rq_level) > CMP_W'(flush_limit_ff));

   assign lval = lrd_valid_ff ? lrd_ff : 16'd0;
   assign rval = rrd_valid_ff ? rrd_ff : 16'd0;

   // register file read addresses: matched fronts during merge, else command slot
   assign l_raddr = (state_ff == S_MRG_CMP) ? lq_slot : slot_ff;
   assign r_raddr = (state_ff == S_MRG_CMP) ? rq_slot : slot_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      read_in      = read_ff;
      match_in     = match_ff;
      flushed_in   = flushed_ff;
      overflow_in  = overflow_ff;
      prev_tag_in  = prev_tag_ff;
      col_pos_in   = col_pos_ff;
      mls_in       = mls_ff;
      mrs_in       = mrs_ff;
      rsp_valid_in = 1'b0;
      lq_ctl       = '0;
      rq_ctl       = '0;
      l_we         = 1'b0;
      r_we         = 1'b0;
      l_waddr      = slot_ff;
      r_waddr      = slot_ff;
      l_wdata      = data_ff;
      r_wdata      = data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               read_in     = '0;
               match_in    = '0;
               flushed_in  = 1'b0;
               overflow_in = 1'b0;
               state_in    = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_RESP;
            case (mode_ff)
               MODE_PUSH_LEFT: begin
                  if (index_ff != 32'd0) begin
                     if (lq_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        lq_ctl.push = 1'b1;
                     end
                  end
               end
               MODE_PUSH_RIGHT: begin
                  if (index_ff != 32'd0) begin
                     if (rq_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        rq_ctl.push = 1'b1;
                     end
                  end
               end
               MODE_REG_WRITE: begin
                  l_we = !side_ff;
                  r_we = side_ff;
               end
               MODE_REG_READ: begin
                  state_in = S_REG_RD;
               end
               MODE_RUN: begin
                  if (col_pos_ff != 3'd0 && prev_tag_ff != tag_ff) begin
                     if (flush_side_ff == SIDE_LEFT) begin
                        lq_ctl.clear = 1'b1;
                     end else begin
                        rq_ctl.clear = 1'b1;
                     end
                     flushed_in = 1'b1;
                  end
                  prev_tag_in = tag_ff;
                  col_pos_in  = (col_pos_ff < COLUMN_WRAP) ? col_pos_ff + 3'd1 : 3'd0;
                  state_in    = S_MRG_RD;
               end
               MODE_FLUSH: begin
                  lq_ctl.clear = 1'b1;
                  rq_ctl.clear = 1'b1;
                  flushed_in   = 1'b1;
               end
               default: begin
               end
            endcase
         end

         S_REG_RD: begin
            read_in  = side_ff ? rval : lval;
            state_in = S_RESP;
         end

         // fronts are read from the heads during this cycle
         S_MRG_RD: begin
            if (lq_level == '0 || rq_level == '0) begin
               state_in = S_LIMIT;
            end else begin
               state_in = S_MRG_CMP;
            end
         end

         S_MRG_CMP: begin
            if (fronts_equal) begin
               lq_ctl.pop = 1'b1;
               rq_ctl.pop = 1'b1;
               mls_in     = lq_slot;
               mrs_in     = rq_slot;
               state_in   = S_MAT_WR;
            end else begin
               if (left_greater) begin
                  rq_ctl.pop = 1'b1;
               end else begin
                  lq_ctl.pop = 1'b1;
               end
               state_in = S_MRG_RD;
            end
         end

         // accumulate right into left, clear right
         S_MAT_WR: begin
            l_we     = 1'b1;
            l_waddr  = mls_ff;
            l_wdata  = lval + rval;
            r_we     = 1'b1;
            r_waddr  = mrs_ff;
            r_wdata  = 16'd0;
            match_in = (match_ff == FIELD5_MAX) ? match_ff : match_ff + 5'd1;
            state_in = S_MRG_RD;
         end

         S_LIMIT: begin
            if (over_limit) begin
               lq_ctl.clear = 1'b1;
               rq_ctl.clear = 1'b1;
               flushed_in   = 1'b1;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         prev_tag_ff    <= '0;
         col_pos_ff     <= '0;
         flush_side_ff  <= SIDE_RIGHT;
         flush_limit_ff <= LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
         lvalid_ff      <= '0;
         rvalid_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         prev_tag_ff  <= prev_tag_in;
         col_pos_ff   <= col_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FLUSH_SIDE:  flush_side_ff  <= csr_data[0];
               CSR_FLUSH_LIMIT: flush_limit_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (l_we) begin
            lvalid_ff[l_waddr] <= 1'b1;
         end
         if (r_we) begin
            rvalid_ff[r_waddr] <= 1'b1;
         end
      end
   end

   // payload and status registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         side_ff  <= req_side;
         slot_ff  <= slot_red;
         index_ff <= req_index_value;
         data_ff  <= req_reg_data;
         tag_ff   <= req_column_tag;
      end
      read_ff     <= read_in;
      match_ff    <= match_in;
      flushed_ff  <= flushed_in;
      overflow_ff <= overflow_in;
      mls_ff      <= mls_in;
      mrs_ff      <= mrs_in;
      if (rsp_valid_in) begin
         rsp_read_ff     <= read_ff;
         rsp_match_ff    <= match_ff;
         rsp_left_ff     <= sat5(lq_level);
         rsp_right_ff    <= sat5(rq_level);
         rsp_flushed_ff  <= flushed_ff;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   // register files, read data registered
   always_ff @(posedge clock) begin
      if (l_we) begin
         left_rf_mem[l_waddr] <= l_wdata;
      end
      if (r_we) begin
         right_rf_mem[r_waddr] <= r_wdata;
      end
      lrd_ff       <= left_rf_mem[l_raddr];
      rrd_ff       <= right_rf_mem[r_raddr];
      lrd_valid_ff <= lvalid_ff[l_raddr];
      rrd_valid_ff <= rvalid_ff[r_raddr];
   end

   siam_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .SLOT_W (SLOT_W)
   ) u_left_queue (
      .clock       (clock),
      .reset       (reset),
      .ctl         (lq_ctl),
      .wr_slot     (slot_ff),
      .wr_index    (index_ff),
      .front_slot  (lq_slot),
      .front_index (lq_index),
      .level       (lq_level)
   );

   siam_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .SLOT_W (SLOT_W)
   ) u_right_queue (
      .clock       (clock),
      .reset       (reset),
      .ctl         (rq_ctl),
      .wr_slot     (slot_ff),
      .wr_index    (index_ff),
      .front_slot  (rq_slot),
      .front_index (rq_index),
      .level       (rq_level)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_ff;
   assign rsp_match_count = rsp_match_ff;
   assign rsp_left_level  = rsp_left_ff;
   assign rsp_right_level = rsp_right_ff;
   assign rsp_flushed     = rsp_flushed_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   a_strobe_from_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == S_RESP)
      else $error("result strobe without a finished word");

   a_merge_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MRG_CMP |-> (lq_level != '0 && rq_level != '0))
      else $error("merge compare on an empty queue");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted word not executed");

   a_match_pops_both: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAT_WR |-> $past(lq_ctl.pop) && $past(rq_ctl.pop))
      else $error("match without popping both fronts");

endmodule

`default_nettype wire

FILE: sim/tb_siam_pkg.sv
`default_nettype none

package tb_siam_pkg;
   import siam_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int REG_SLOTS   = 16;

   // One command word as it sits on the req_ ports
   typedef struct packed {
      logic [2:0]  mode;
      logic        side;
      logic [3:0]  slot;
      logic [31:0] index_value;
      logic [15:0] reg_data;
      logic [31:0] column_tag;
   } cmd_word_type;

   // One result word as it sits on the rsp_ ports
   typedef struct packed {
      logic [15:0] read_data;
      logic [4:0]  match_count;
      logic [4:0]  left_level;
      logic [4:0]  right_level;
      logic        flushed;
      logic        overflow;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic [31:0] index_value;
   } queue_entry_type;

   // Mirror of the two index queues and register files; predicts one
   // result word per accepted command word and checks them in order
   class match_accumulator_mirror;
      logic            flush_side;
      logic [4:0]      flush_limit;
      queue_entry_type left_q[$];
      queue_entry_type right_q[$];
      logic [15:0]     left_regs[REG_SLOTS];
      logic [15:0]     right_regs[REG_SLOTS];
      logic [31:0]     last_tag;
      logic [2:0]      column_pos;
      rsp_word_type    pending_reports[$];
      int unsigned     failures;

      function new();
         flush_side  = SIDE_RIGHT;
         flush_limit = LIMIT_RESET;
         last_tag    = '0;
         column_pos  = '0;
         failures    = 0;
         foreach (left_regs[i]) begin
            left_regs[i]  = '0;
            right_regs[i] = '0;
         end
      endfunction

      function void write_csr(logic idx, logic [4:0] data);
         if (idx == CSR_FLUSH_SIDE) begin
            flush_side = data[0];
         end else begin
            flush_limit = data;
         end
      endfunction

      function void note_word(cmd_word_type w);
         rsp_word_type    r;
         queue_entry_type lf;
         queue_entry_type rf;
         queue_entry_type ent;
         int              match_total;
         r = '0;
         match_total = 0;
         ent = {w.slot, w.index_value};
         case (w.mode)
            MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
               // zero indices are dropped silently, full queues flag overflow
               if (w.index_value != 0) begin
                  if (w.mode == MODE_PUSH_LEFT) begin
                     if (left_q.size() >= QUEUE_DEPTH) r.overflow = 1'b1;
                     else left_q = {left_q, ent};
                  end else begin
                     if (right_q.size() >= QUEUE_DEPTH) r.overflow = 1'b1;
                     else right_q = {right_q, ent};
                  end
               end
            end
            MODE_REG_WRITE: begin
               if (w.side) right_regs[w.slot] = w.reg_data;
               else left_regs[w.slot] = w.reg_data;
            end
            MODE_REG_READ: begin
               r.read_data = w.side ? right_regs[w.slot] : left_regs[w.slot];
            end
            MODE_RUN: begin
               // column change flushes the configured side, even if empty
               if (column_pos != 0 && last_tag != w.column_tag) begin
                  if (flush_side == SIDE_LEFT) left_q.delete();
                  else right_q.delete();
                  r.flushed = 1'b1;
               end
               last_tag   = w.column_tag;
               column_pos = (column_pos == COLUMN_WRAP) ? 3'd0 : column_pos + 3'd1;
               // sorted merge of the fronts
               while (left_q.size() != 0 && right_q.size() != 0) begin
                  lf = left_q[0];
                  rf = right_q[0];
                  if (lf.index_value == rf.index_value) begin
                     left_regs[lf.slot]  = left_regs[lf.slot] + right_regs[rf.slot];
                     right_regs[rf.slot] = '0;
                     void'(left_q.pop_front());
                     void'(right_q.pop_front());
                     match_total++;
                  end else if (lf.index_value > rf.index_value) begin
                     void'(right_q.pop_front());
                  end else begin
                     void'(left_q.pop_front());
                  end
               end
               if (left_q.size() > flush_limit || right_q.size() > flush_limit) begin
                  left_q.delete();
                  right_q.delete();
                  r.flushed = 1'b1;
               end
            end
            MODE_FLUSH: begin
               left_q.delete();
               right_q.delete();
               r.flushed = 1'b1;
            end
            default: begin
            end
         endcase
         r.match_count = 5'(match_total);
         r.left_level  = 5'(left_q.size());
         r.right_level = 5'(right_q.size());
         pending_reports = {pending_reports, r};
      endfunction

      function void compare_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            failures++;
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp;
         if (pending_reports.size() == 0) begin
            $error("result word with no command outstanding");
            failures++;
         end else begin
            exp = pending_reports.pop_front();
            compare_field("read_data",   exp.read_data,   got.read_data);
            compare_field("match_count", exp.match_count, got.match_count);
            compare_field("left_level",  exp.left_level,  got.left_level);
            compare_field("right_level", exp.right_level, got.right_level);
            compare_field("flushed",     exp.flushed,     got.flushed);
            compare_field("overflow",    exp.overflow,    got.overflow);
         end
      endfunction
   endclass

endpackage

`default_nettype wire

FILE: sim/tb_sparse_index_match_accumulator_core.sv
`default_nettype none

module tb_sparse_index_match_accumulator_core;
   import siam_pkg::*;
   import tb_siam_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_WORDS = 236;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_mode;
   logic        req_side;
   logic [3:0]  req_slot;
   logic [31:0] req_index_value;
   logic [15:0] req_reg_data;
   logic [31:0] req_column_tag;
   logic        rsp_valid;
   logic [15:0] rsp_read_data;
   logic [4:0]  rsp_match_count;
   logic [4:0]  rsp_left_level;
   logic [4:0]  rsp_right_level;
   logic        rsp_flushed;
   logic        rsp_overflow;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [4:0]  csr_data;

   match_accumulator_mirror mirror = new();

   int unsigned words_sent;
   int unsigned idle_pct;
   logic [31:0] run_tag;

   sparse_index_match_accumulator_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_side        (req_side),
      .req_slot        (req_slot),
      .req_index_value (req_index_value),
      .req_reg_data    (req_reg_data),
      .req_column_tag  (req_column_tag),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_match_count (rsp_match_count),
      .rsp_left_level  (rsp_left_level),
      .rsp_right_level (rsp_right_level),
      .rsp_flushed     (rsp_flushed),
      .rsp_overflow    (rsp_overflow),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Observe the result, configuration and command channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            mirror.check_result({rsp_read_data, rsp_match_count, rsp_left_level,
                                 rsp_right_level, rsp_flushed, rsp_overflow});
         end
         if (csr_valid && csr_ready) mirror.write_csr(csr_index, csr_data);
         if (start && !busy) begin
            mirror.note_word({req_mode, req_side, req_slot, req_index_value,
                              req_reg_data, req_column_tag});
         end
      end
   end

   function automatic cmd_word_type make_word(logic [2:0] mode, logic side, logic [3:0] slot,
                                              logic [31:0] idx, logic [15:0] data,
                                              logic [31:0] tag);
      cmd_word_type w;
      w.mode        = mode;
      w.side        = side;
      w.slot        = slot;
      w.index_value = idx;
      w.reg_data    = data;
      w.column_tag  = tag;
      return w;
   endfunction

   // Present one word, random sender gaps first; returns at the accepting edge
   task automatic send_word(cmd_word_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_mode        <= w.mode;
      req_side        <= w.side;
      req_slot        <= w.slot;
      req_index_value <= w.index_value;
      req_reg_data    <= w.reg_data;
      req_column_tag  <= w.column_tag;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (mirror.pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_reg_access();
      if ($urandom_range(0, 1))
         send_word(make_word(MODE_REG_WRITE, 1'($urandom), 4'($urandom), $urandom,
                             16'($urandom), $urandom));
      else
         send_word(make_word(MODE_REG_READ, 1'($urandom), 4'($urandom), $urandom,
                             16'($urandom), $urandom));
   endtask

   // Two sorted index streams from a shared base, then a run, with random register accesses before and after
   task automatic send_merge_sequence();
      int unsigned n_left;
      int unsigned n_right;
      logic [31:0] left_idx;
      logic [31:0] right_idx;
      n_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 8);
      n_right = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 8);
      left_idx  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
      right_idx = left_idx;
      repeat ($urandom_range(0, 2)) send_random_reg_access();
      while (n_left != 0 || n_right != 0) begin
         if (n_right == 0 || (n_left != 0 && $urandom_range(0, 1))) begin
            left_idx += $urandom_range(1, 3);
            send_word(make_word(MODE_PUSH_LEFT, 1'($urandom), 4'($urandom), left_idx,
                                16'($urandom), $urandom));
            n_left--;
         end else begin
            right_idx += $urandom_range(1, 3);
            send_word(make_word(MODE_PUSH_RIGHT, 1'($urandom), 4'($urandom), right_idx,
                                16'($urandom), $urandom));
            n_right--;
         end
      end
      // mostly the same column, sometimes a new one
      if ($urandom_range(0, 3) == 0) run_tag = $urandom;
      send_word(make_word(MODE_RUN, 1'($urandom), 4'($urandom), $urandom,
                          16'($urandom), run_tag));
      repeat ($urandom_range(0, 2)) send_random_reg_access();
   endtask

   // Unstructured words over every mode, unused ones included
   task automatic send_noise();
      logic [31:0] idx;
      logic [31:0] tag;
      repeat ($urandom_range(1, 4)) begin
         idx = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
         tag = $urandom_range(0, 1) ? $urandom : run_tag;
         send_word(make_word(3'($urandom_range(0, 7)), 1'($urandom), 4'($urandom), idx,
                             16'($urandom), tag));
      end
   endtask

   task automatic send_directed();
      // zero index, all-ones index on both sides, wrapping accumulate
      send_word(make_word(MODE_PUSH_LEFT,  1'b0, 4'd0,  32'd0,        16'd0,      32'd0));
      send_word(make_word(MODE_PUSH_LEFT,  1'b0, 4'd15, 32'hFFFF_FFFF, 16'd0,     32'd0));
      send_word(make_word(MODE_PUSH_RIGHT, 1'b1, 4'd15, 32'hFFFF_FFFF, 16'd0,     32'd0));
      send_word(make_word(MODE_REG_WRITE,  1'b1, 4'd15, 32'd0,        16'hFFFF,   32'd0));
      send_word(make_word(MODE_REG_WRITE,  1'b0, 4'd15, 32'd0,        16'h0001,   32'd0));
      send_word(make_word(MODE_REG_READ,   1'b0, 4'd15, 32'd0,        16'd0,      32'd0));
      send_word(make_word(MODE_RUN,        1'b0, 4'd0,  32'd0,        16'd0,      32'd0));
      send_word(make_word(MODE_REG_READ,   1'b0, 4'd15, 32'd0,        16'd0,      32'd0));
      send_word(make_word(MODE_REG_READ,   1'b1, 4'd15, 32'd0,        16'd0,      32'd0));
      // column change flushes one side even though it holds an entry
      send_word(make_word(MODE_PUSH_LEFT,  1'b0, 4'd0,  32'd1,        16'd0,      32'd0));
      send_word(make_word(MODE_PUSH_RIGHT, 1'b0, 4'd1,  32'd2,        16'd0,      32'd0));
      send_word(make_word(MODE_RUN,        1'b0, 4'd0,  32'd0,        16'd0,  32'hFFFF_FFFF));
      // same column: smaller side pops until left is empty
      send_word(make_word(MODE_PUSH_RIGHT, 1'b0, 4'd3,  32'd5,        16'd0,      32'd0));
      send_word(make_word(MODE_RUN,        1'b0, 4'd0,  32'd0,        16'd0,  32'hFFFF_FFFF));
      send_word(make_word(MODE_FLUSH,      1'b0, 4'd0,  32'd0,        16'd0,      32'd0));
      // unused modes with every field bit set
      send_word(make_word(3'd6, 1'b1, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_word(make_word(3'd7, 1'b1, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_word(make_word(MODE_REG_WRITE,  1'b0, 4'd0,  32'd0,        16'hA5A5,   32'd0));
      send_word(make_word(MODE_REG_READ,   1'b0, 4'd0,  32'd0,        16'd0,      32'd0));
      send_word(make_word(MODE_REG_READ,   1'b1, 4'd0,  32'd0,        16'd0,      32'd0));
      send_word(make_word(MODE_REG_WRITE,  1'b1, 4'd0,  32'd0,        16'h5A5A,   32'd0));
      send_word(make_word(MODE_REG_READ,   1'b1, 4'd0,  32'd0,        16'd0,      32'd0));
   endtask

   // Run ends here if the block hangs
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int unsigned target;
      logic [4:0]  limits[6];
      int unsigned gaps[6];
      int unsigned kind;
      limits = '{LIMIT_RESET, 5'd16, 5'd1, 5'd0, 5'd31, 5'($urandom)};
      gaps   = '{0, 51, 33, 0, 51, 33};
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = '0;
      req_side        = 1'b0;
      req_slot        = '0;
      req_index_value = '0;
      req_reg_data    = '0;
      req_column_tag  = '0;
      csr_valid       = 1'b0;
      csr_index       = 1'b0;
      csr_data        = '0;
      words_sent      = 0;
      idle_pct        = 0;
      run_tag         = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_directed();
      drain();

      // phases of different configuration and sender idling
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_FLUSH_SIDE, {4'd0, 1'(p % 2)});
         write_csr(CSR_FLUSH_LIMIT, limits[p]);
         idle_pct = gaps[p];
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) send_merge_sequence();
            else if (kind <= 7) repeat ($urandom_range(1, 4)) send_random_reg_access();
            else send_noise();
         end
         drain();
      end

      if (mirror.failures == 0 && mirror.pending_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/siam_pkg.sv
rtl/siam_queue.sv
rtl/sparse_index_match_accumulator_core.sv
sim/tb_siam_pkg.sv
sim/tb_sparse_index_match_accumulator_core.sv
